// ===== hdl/oal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list package
// Request kinds, status codes and fixed field widths shared by the
// interfaces and the engine.
// ----------------------------------------------------------------------------
package oal_pkg;

   localparam int KIND_BITS     = 3;
   localparam int POSITION_BITS = 9;
   localparam int ITEM_BITS     = 32;
   localparam int STATUS_BITS   = 2;
   localparam int TALLY_BITS    = 9;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_INSERT = 3'd2,
      KIND_REMOVE = 3'd3,
      KIND_GET    = 3'd4,
      KIND_SET    = 3'd5,
      KIND_COUNT  = 3'd6
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

// ===== hdl/oal_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list channels
// Valid/ready request and response channels; a transaction moves on a
// rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface oal_req_if;
   import oal_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [KIND_BITS-1:0]     kind;
   logic [POSITION_BITS-1:0] position;
   logic [ITEM_BITS-1:0]     item_value;

   modport source (output valid, kind, position, item_value, input ready);
   modport sink   (input valid, kind, position, item_value, output ready);
endinterface

interface oal_rsp_if;
   import oal_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [ITEM_BITS-1:0]   read_value;
   logic [TALLY_BITS-1:0]  tally;

   modport source (output valid, status, read_value, tally, input ready);
   modport sink   (input valid, status, read_value, tally, output ready);
endinterface

// ===== hdl/oal_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list entry store
// Simple dual-port synchronous memory: one write, one registered read.
// ----------------------------------------------------------------------------
module oal_store #(
   parameter int DEPTH      = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [VALUE_BITS-1:0]      wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [VALUE_BITS-1:0]      rd_data
);

   logic [VALUE_BITS-1:0] mem [DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ordered_array_list_engine.sv =====
// Push, set, unknown kinds and refused requests pass through the decode,
// finish and response states; pop, get, insert, remove and count also walk
// entries in the scan state, one per cycle through the single port pair of
// the store, at most DEPTH of them. One request is taken at a time; a
// finished response may wait while the next is taken. Reset clears the
// state, length, walk and response valid, not the store or data registers.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine
// Fixed-capacity ordered list held in a synchronous memory: push, pop,
// insert, remove, get, set and count, walked one entry per cycle.
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
   parameter int DEPTH      = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   oal_req_if.sink   req_bus,
   oal_rsp_if.source rsp_bus
);
   import oal_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = (LW > POSITION_BITS) ? LW : POSITION_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FINISH,
      S_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [KIND_BITS-1:0]     kind_ff, kind_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [VALUE_BITS-1:0]    val_ff, val_in;
   logic [LW-1:0]            len_ff, len_in;
   logic [AW-1:0]            scan_addr_ff, scan_addr_in;
   logic [LW-1:0]            scan_left_ff, scan_left_in;
   logic                     scan_up_ff, scan_up_in;
   logic                     ret_valid_ff, ret_valid_in;
   logic [AW-1:0]            ret_addr_ff, ret_addr_in;
   status_type               status_ff, status_in;
   logic [VALUE_BITS-1:0]    rd_ff, rd_in;
   logic [LW-1:0]            tally_ff, tally_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [ITEM_BITS-1:0]     rsp_read_ff, rsp_read_in;
   logic [TALLY_BITS-1:0]    rsp_tally_ff, rsp_tally_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [VALUE_BITS-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [VALUE_BITS-1:0] mem_rdata;

   logic [CW-1:0] pos_ext;
   logic [CW-1:0] len_ext;
   logic          full;
   logic          empty;

   oal_store #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign pos_ext = CW'(pos_ff);
   assign len_ext = CW'(len_ff);
   assign full    = (len_ff == LW'(DEPTH));
   assign empty   = (len_ff == '0);

   assign req_bus.ready      = (state_ff == S_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.read_value = rsp_read_ff;
   assign rsp_bus.tally      = rsp_tally_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      len_in        = len_ff;
      scan_addr_in  = scan_addr_ff;
      scan_left_in  = scan_left_ff;
      scan_up_in    = scan_up_ff;
      ret_valid_in  = ret_valid_ff;
      ret_addr_in   = ret_addr_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      tally_in      = tally_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_tally_in  = rsp_tally_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = val_ff;
      mem_re        = 1'b0;
      mem_raddr     = scan_addr_ff;

      // drop the response once the sink has taken it
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               kind_in   = req_bus.kind;
               pos_in    = req_bus.position;
               val_in    = VALUE_BITS'(req_bus.item_value);
               status_in = ST_OK;
               rd_in     = '0;
               tally_in  = '0;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_FINISH;
            case (kind_ff)
               KIND_PUSH: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(len_ff);
                     len_in    = len_ff + LW'(1);
                  end
               end
               KIND_POP: begin
                  if (empty) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     scan_addr_in = AW'(len_ff - LW'(1));
                     scan_left_in = LW'(1);
                     scan_up_in   = 1'b1;
                     len_in       = len_ff - LW'(1);
                     state_in     = S_SCAN;
                  end
               end
               KIND_INSERT: begin
                  if (pos_ext > len_ext) begin
                     status_in = ST_BAD_INDEX;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     // walk from the tail down to the insert point
                     scan_addr_in = AW'(len_ff - LW'(1));
                     scan_left_in = LW'(len_ext - pos_ext);
                     scan_up_in   = 1'b0;
                     state_in     = S_SCAN;
                  end
               end
               KIND_REMOVE: begin
                  if (pos_ext >= len_ext) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     scan_addr_in = AW'(pos_ff);
                     scan_left_in = LW'(len_ext - pos_ext);
                     scan_up_in   = 1'b1;
                     len_in       = len_ff - LW'(1);
                     state_in     = S_SCAN;
                  end
               end
               KIND_GET: begin
                  if (pos_ext >= len_ext) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     scan_addr_in = AW'(pos_ff);
                     scan_left_in = LW'(1);
                     scan_up_in   = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               KIND_SET: begin
                  if (pos_ext >= len_ext) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = AW'(pos_ff);
                  end
               end
               KIND_COUNT: begin
                  scan_addr_in = '0;
                  scan_left_in = len_ff;
                  scan_up_in   = 1'b1;
                  state_in     = S_SCAN;
               end
               default: begin
               end
            endcase
         end

         S_SCAN: begin
            // issue the next read while the previous one returns
            if (scan_left_ff != '0) begin
               mem_re       = 1'b1;
               scan_addr_in = scan_up_ff ? scan_addr_ff + AW'(1) : scan_addr_ff - AW'(1);
               scan_left_in = scan_left_ff - LW'(1);
               ret_valid_in = 1'b1;
               ret_addr_in  = scan_addr_ff;
            end else begin
               ret_valid_in = 1'b0;
            end

            if (ret_valid_ff) begin
               case (kind_ff)
                  KIND_POP, KIND_GET: begin
                     rd_in = mem_rdata;
                  end
                  KIND_REMOVE: begin
                     if (ret_addr_ff == AW'(pos_ff)) begin
                        rd_in = mem_rdata;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ret_addr_ff - AW'(1);
                        mem_wdata = mem_rdata;
                     end
                  end
                  KIND_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = ret_addr_ff + AW'(1);
                     mem_wdata = mem_rdata;
                  end
                  KIND_COUNT: begin
                     if (mem_rdata == val_ff) begin
                        tally_in = tally_ff + LW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if ((scan_left_ff == '0) && !ret_valid_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if ((kind_ff == KIND_INSERT) && (status_ff == ST_OK)) begin
               mem_we    = 1'b1;
               mem_waddr = AW'(pos_ff);
               len_in    = len_ff + LW'(1);
            end
            if (kind_ff != KIND_COUNT) begin
               tally_in = len_in;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_read_in   = ITEM_BITS'(rd_ff);
               rsp_tally_in  = TALLY_BITS'(tally_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      scan_addr_ff  <= scan_addr_in;
      scan_up_ff    <= scan_up_in;
      ret_addr_ff   <= ret_addr_in;
      status_ff     <= status_in;
      rd_ff         <= rd_in;
      tally_ff      <= tally_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_tally_ff  <= rsp_tally_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         scan_left_ff <= '0;
         ret_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         scan_left_ff <= scan_left_in;
         ret_valid_ff <= ret_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(DEPTH))
      else $error("list length beyond capacity");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> (scan_left_ff == '0) && !ret_valid_ff)
      else $error("request taken while a walk is still running");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("read and write to the same entry in one cycle");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside the response state");
`endif

endmodule
